/* rtl/core/lcff_pkg.sv */
// Shared types, widths and register codes of the load-cell force filter.
package lcff_pkg;

  localparam int SampleW    = 24;
  localparam int WinSamples = 8;
  localparam int WinIdxW    = $clog2(WinSamples);
  localparam int FillW      = $clog2(WinSamples + 1);
  localparam int SumW       = SampleW + WinIdxW;
  // Reciprocal scaling for the mean: exact for every sum and fill count.
  localparam int RecipShift = SumW + WinIdxW;
  localparam int RecipW     = RecipShift + 1;

  localparam int ForceW   = 32;
  localparam int GainW    = 40;
  localparam int GainLoW  = 16;
  localparam int GainHiW  = GainW - GainLoW;
  localparam int LimitW   = 31;
  localparam int AlphaW   = 17;
  localparam int TimeoutW = 16;
  localparam int IdleW    = 17;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = GainW;

  // Magnitude of an offset-corrected count fits in the sample width.
  localparam int MagW   = SampleW;
  localparam int ScaleW = MagW + GainHiW + 1;

  localparam int MulAW = ForceW;
  localparam int MulBW = RecipW;
  localparam int ProdW = MulAW + MulBW;

  localparam logic [AlphaW-1:0] AlphaOne = AlphaW'(65536);
  localparam logic [IdleW-1:0]  IdleMax  = '1;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZERO_OFFSET  = 3'd0,
    CFG_GAIN         = 3'd1,
    CFG_INVERT_SIGN  = 3'd2,
    CFG_GLITCH_LIMIT = 3'd3,
    CFG_FAST_ALPHA   = 3'd4,
    CFG_TIMEOUT_MS   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                      command;
    logic signed [SampleW-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [ForceW-1:0]  force_average;
    logic signed [ForceW-1:0]  force_fast;
    logic signed [SampleW-1:0] mean_raw;
    logic                      sample_error;
    logic                      glitch_rejected;
    logic                      forces_updated;
  } out_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] zero_offset;
    logic [GainW-1:0]          gain;
    logic                      invert_sign;
    logic [LimitW-1:0]         glitch_limit;
    logic [AlphaW-1:0]         fast_alpha;
    logic [TimeoutW-1:0]       timeout_ms;
  } cfg_t;

endpackage

/* rtl/core/lcff_window.sv */
// Sliding window of recent samples with running sum and fill count.
module lcff_window (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic signed [lcff_pkg::SampleW-1:0] raw_i,
  output logic signed [lcff_pkg::SumW-1:0]    sum_o,
  output logic [lcff_pkg::FillW-1:0]          fill_o
);
  import lcff_pkg::*;

  logic signed [SampleW-1:0] store_q [WinSamples];
  logic [WinIdxW-1:0]        idx_q;
  logic signed [SumW-1:0]    sum_q;
  logic [FillW-1:0]          fill_q;
  logic signed [SampleW-1:0] old_smp;

  assign old_smp = store_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinSamples; i++) store_q[i] <= '0;
      idx_q  <= '0;
      sum_q  <= '0;
      fill_q <= '0;
    end else if (push_i) begin
      store_q[idx_q] <= raw_i;
      sum_q <= sum_q - {{WinIdxW{old_smp[SampleW-1]}}, old_smp}
                     + {{WinIdxW{raw_i[SampleW-1]}}, raw_i};
      if (idx_q == WinIdxW'(WinSamples - 1)) begin
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
      if (fill_q != FillW'(WinSamples)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

endmodule

/* rtl/core/lcff_mul.sv */
// Shared unsigned multiplier with a registered product.
module lcff_mul (
  input  logic                       clk_i,
  input  logic [lcff_pkg::MulAW-1:0] a_i,
  input  logic [lcff_pkg::MulBW-1:0] b_i,
  output logic [lcff_pkg::ProdW-1:0] prod_o
);
  import lcff_pkg::*;

  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/lcff_core.sv */
// Sequencer and datapath: mean, scaling, glitch test, fast filter, result register.
module lcff_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lcff_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lcff_pkg::out_item_t                 out_data_o,
  input  lcff_pkg::cfg_t                      cfg_i,
  output logic                                win_push_o,
  output logic signed [lcff_pkg::SampleW-1:0] win_raw_o,
  input  logic signed [lcff_pkg::SumW-1:0]    win_sum_i,
  input  logic [lcff_pkg::FillW-1:0]          win_fill_i,
  output logic [lcff_pkg::MulAW-1:0]          mul_a_o,
  output logic [lcff_pkg::MulBW-1:0]          mul_b_o,
  input  logic [lcff_pkg::ProdW-1:0]          mul_prod_i
);
  import lcff_pkg::*;

  localparam int LoPW  = MagW + GainLoW;
  localparam int RndW  = LoPW + 1 - GainLoW;
  localparam int FPW   = ForceW + AlphaW;
  localparam int StepW = FPW + 1 - GainLoW;
  localparam int NewW  = ForceW + 3;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_DIV   = 14'b00000000000010,
    ST_MEAN  = 14'b00000000000100,
    ST_DIFF  = 14'b00000000001000,
    ST_MAH   = 14'b00000000010000,
    ST_MAL   = 14'b00000000100000,
    ST_MRH   = 14'b00000001000000,
    ST_MRL   = 14'b00000010000000,
    ST_CHK   = 14'b00000100000000,
    ST_FORCE = 14'b00001000000000,
    ST_DLT   = 14'b00010000000000,
    ST_FMUL  = 14'b00100000000000,
    ST_FADD  = 14'b01000000000000,
    ST_WRITE = 14'b10000000000000
  } state_e;

  function automatic logic [ScaleW-1:0] round_lo(input logic [LoPW-1:0] p);
    logic [LoPW:0] s;
    s = {1'b0, p} + (LoPW + 1)'(1 << (GainLoW - 1));
    return ScaleW'(s[LoPW:GainLoW]);
  endfunction

  function automatic logic signed [ForceW-1:0] sat_force(input logic [ScaleW-1:0] mag,
                                                          input logic neg);
    logic signed [ForceW-1:0] res;
    // Magnitudes of 2^31 and above clip to the signed range in both directions.
    if (mag[ScaleW-1:ForceW-1] != '0) begin
      res = neg ? {1'b1, {(ForceW-1){1'b0}}} : {1'b0, {(ForceW-1){1'b1}}};
    end else begin
      res = neg ? -$signed(mag[ForceW-1:0]) : $signed(mag[ForceW-1:0]);
    end
    return res;
  endfunction

  state_e state_q, state_d;

  logic [RecipW-1:0] recip_tbl [WinSamples+1];
  assign recip_tbl[0] = '0;
  for (genvar g = 1; g <= WinSamples; g++) begin : g_recip
    localparam logic [RecipW-1:0] Recip =
      RecipW'(((64'd1 << RecipShift) + 64'(g) - 64'd1) / 64'(g));
    assign recip_tbl[g] = Recip;
  end

  logic                      cmd_q;
  logic signed [SampleW-1:0] raw_q;
  logic signed [SampleW-1:0] mean_q;
  logic [MagW-1:0]           mag_a_q, mag_r_q;
  logic                      neg_a_q, neg_r_q;
  logic [ScaleW-1:0]         sa_q, sr_q;
  logic signed [ForceW-1:0]  fr_q;
  logic [ForceW-1:0]         dm_q;
  logic                      dneg_q;
  logic                      glitch_q, updated_q;
  logic signed [ForceW-1:0]  avg_q, fast_q;
  logic                      started_q;
  logic [IdleW-1:0]          idle_q;
  logic                      tflag_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic                      accept;
  logic                      slot_free;
  logic [SumW-1:0]           sum_mag;
  logic [SampleW-1:0]        mean_mag;
  logic signed [MagW:0]      diff_a, diff_r;
  logic [MagW:0]             abs_a, abs_r;
  logic [AlphaW-1:0]         alpha_sat;
  logic                      glitch;
  logic signed [ForceW-1:0]  fa, fr;
  logic signed [ForceW:0]    dlt;
  logic [ForceW:0]           dlt_abs;
  logic [FPW:0]              fsum;
  logic [StepW-1:0]          step_mag;
  logic signed [NewW-1:0]    fast_new;
  logic signed [ForceW-1:0]  fast_sat;
  logic [IdleW-1:0]          idle_inc;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  assign win_push_o = accept && (in_data_i.command == CmdSample);
  assign win_raw_o  = in_data_i.raw_sample;

  assign sum_mag  = win_sum_i[SumW-1] ? SumW'(-win_sum_i) : SumW'(win_sum_i);
  assign mean_mag = mul_prod_i[RecipShift +: SampleW];

  assign diff_a = {mean_q[SampleW-1], mean_q} - {cfg_i.zero_offset[SampleW-1], cfg_i.zero_offset};
  assign diff_r = {raw_q[SampleW-1], raw_q} - {cfg_i.zero_offset[SampleW-1], cfg_i.zero_offset};
  assign abs_a  = diff_a[MagW] ? (MagW + 1)'(-diff_a) : (MagW + 1)'(diff_a);
  assign abs_r  = diff_r[MagW] ? (MagW + 1)'(-diff_r) : (MagW + 1)'(diff_r);

  assign alpha_sat = (cfg_i.fast_alpha > AlphaOne) ? AlphaOne : cfg_i.fast_alpha;

  assign glitch = (sa_q > ScaleW'(cfg_i.glitch_limit)) || (sr_q > ScaleW'(cfg_i.glitch_limit));
  assign fa     = sat_force(sa_q, neg_a_q);
  assign fr     = sat_force(sr_q, neg_r_q);

  assign dlt     = {fr_q[ForceW-1], fr_q} - {fast_q[ForceW-1], fast_q};
  assign dlt_abs = dlt[ForceW] ? (ForceW + 1)'(-dlt) : (ForceW + 1)'(dlt);

  assign fsum     = {1'b0, mul_prod_i[FPW-1:0]} + (FPW + 1)'(1 << (GainLoW - 1));
  assign step_mag = fsum[FPW:GainLoW];
  assign fast_new = {{3{fast_q[ForceW-1]}}, fast_q}
                  + (dneg_q ? -$signed(NewW'(step_mag)) : $signed(NewW'(step_mag)));
  always_comb begin
    if (fast_new[NewW-1:ForceW-1] == '0 || fast_new[NewW-1:ForceW-1] == '1) begin
      fast_sat = fast_new[ForceW-1:0];
    end else begin
      fast_sat = fast_new[NewW-1] ? {1'b1, {(ForceW-1){1'b0}}} : {1'b0, {(ForceW-1){1'b1}}};
    end
  end

  assign idle_inc = (idle_q == IdleMax) ? idle_q : idle_q + 1'b1;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a_o = '0;
    mul_b_o = '0;
    case (state_q)
      ST_DIV: begin
        mul_a_o = MulAW'(sum_mag);
        mul_b_o = recip_tbl[win_fill_i];
      end
      ST_MAH: begin
        mul_a_o = MulAW'(mag_a_q);
        mul_b_o = MulBW'(cfg_i.gain[GainW-1:GainLoW]);
      end
      ST_MAL: begin
        mul_a_o = MulAW'(mag_a_q);
        mul_b_o = MulBW'(cfg_i.gain[GainLoW-1:0]);
      end
      ST_MRH: begin
        mul_a_o = MulAW'(mag_r_q);
        mul_b_o = MulBW'(cfg_i.gain[GainW-1:GainLoW]);
      end
      ST_MRL: begin
        mul_a_o = MulAW'(mag_r_q);
        mul_b_o = MulBW'(cfg_i.gain[GainLoW-1:0]);
      end
      ST_FMUL: begin
        mul_a_o = dm_q;
        mul_b_o = MulBW'(alpha_sat);
      end
      default: begin
        mul_a_o = '0;
        mul_b_o = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_DIV;
      ST_DIV:   state_d = ST_MEAN;
      ST_MEAN: begin
        if (cmd_q == CmdTick || cfg_i.gain == '0) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF:  state_d = ST_MAH;
      ST_MAH:   state_d = ST_MAL;
      ST_MAL:   state_d = ST_MRH;
      ST_MRH:   state_d = ST_MRL;
      ST_MRL:   state_d = ST_CHK;
      ST_CHK:   state_d = ST_FORCE;
      ST_FORCE: begin
        if (glitch || !started_q) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_DLT;
        end
      end
      ST_DLT:   state_d = ST_FMUL;
      ST_FMUL:  state_d = ST_FADD;
      ST_FADD:  state_d = ST_WRITE;
      ST_WRITE: if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
      fast_q      <= '0;
      started_q   <= 1'b0;
      idle_q      <= '0;
      tflag_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_WRITE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        if (in_data_i.command == CmdTick) begin
          idle_q <= idle_inc;
          if (32'(idle_inc) > 32'(cfg_i.timeout_ms)) tflag_q <= 1'b1;
        end else begin
          idle_q  <= '0;
          tflag_q <= 1'b0;
        end
      end
      if (state_q == ST_MEAN && cmd_q == CmdSample && cfg_i.gain == '0) begin
        avg_q     <= '0;
        fast_q    <= '0;
        started_q <= 1'b0;
      end
      if (state_q == ST_FORCE && !glitch) begin
        avg_q <= fa;
        if (!started_q) begin
          fast_q    <= fr;
          started_q <= 1'b1;
        end
      end
      if (state_q == ST_FADD) fast_q <= fast_sat;
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_q     <= in_data_i.command;
          raw_q     <= in_data_i.raw_sample;
          glitch_q  <= 1'b0;
          updated_q <= 1'b0;
        end
      end
      ST_MEAN: begin
        mean_q <= win_sum_i[SumW-1] ? -$signed(mean_mag) : $signed(mean_mag);
        if (cmd_q == CmdSample && cfg_i.gain == '0) updated_q <= 1'b1;
      end
      ST_DIFF: begin
        mag_a_q <= abs_a[MagW-1:0];
        mag_r_q <= abs_r[MagW-1:0];
        neg_a_q <= diff_a[MagW] ^ cfg_i.invert_sign;
        neg_r_q <= diff_r[MagW] ^ cfg_i.invert_sign;
      end
      ST_MAL:   sa_q <= ScaleW'(mul_prod_i[MagW+GainHiW-1:0]);
      ST_MRH:   sa_q <= sa_q + round_lo(mul_prod_i[LoPW-1:0]);
      ST_MRL:   sr_q <= ScaleW'(mul_prod_i[MagW+GainHiW-1:0]);
      ST_CHK:   sr_q <= sr_q + round_lo(mul_prod_i[LoPW-1:0]);
      ST_FORCE: begin
        glitch_q  <= glitch;
        updated_q <= !glitch;
        fr_q      <= fr;
      end
      ST_DLT: begin
        dm_q   <= dlt_abs[ForceW-1:0];
        dneg_q <= dlt[ForceW];
      end
      ST_WRITE: begin
        if (slot_free) begin
          out_q.force_average   <= avg_q;
          out_q.force_fast      <= fast_q;
          out_q.mean_raw        <= mean_q;
          out_q.sample_error    <= tflag_q;
          out_q.glitch_rejected <= glitch_q;
          out_q.forces_updated  <= updated_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/load_cell_force_filter_top.sv */
// Top level of the load-cell force filter: configuration registers and block wiring.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  in_data_i   (command, raw_sample)
//   out      output     out_valid_o/out_ready_i out_data_o (forces, mean, flags)
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A tick item passes only the divide, mean and write steps, and a sample item up to
// the full sequence from acceptance until its result is loaded, one item at a time; the
// sample path is set by its six passes through the single shared multiplier (mean, four
// scaling products, filter step). The result register lets the next item enter while a result is
// still waiting. A stalled output holds the sequencer in its last step only.
// Reset clears the window and the filter state and loads the configuration defaults at once.
module load_cell_force_filter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lcff_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lcff_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lcff_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcff_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import lcff_pkg::*;

  cfg_t cfg_q;

  logic                      win_push;
  logic signed [SampleW-1:0] win_raw;
  logic signed [SumW-1:0]    win_sum;
  logic [FillW-1:0]          win_fill;
  logic [MulAW-1:0]          mul_a;
  logic [MulBW-1:0]          mul_b;
  logic [ProdW-1:0]          mul_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_offset  <= '0;
      cfg_q.gain         <= GainW'(64'h1_0000_0000);
      cfg_q.invert_sign  <= 1'b0;
      cfg_q.glitch_limit <= '1;
      cfg_q.fast_alpha   <= AlphaW'(6554);
      cfg_q.timeout_ms   <= TimeoutW'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ZERO_OFFSET:  cfg_q.zero_offset  <= cfg_wdata_i[SampleW-1:0];
        CFG_GAIN:         cfg_q.gain         <= cfg_wdata_i[GainW-1:0];
        CFG_INVERT_SIGN:  cfg_q.invert_sign  <= cfg_wdata_i[0];
        CFG_GLITCH_LIMIT: cfg_q.glitch_limit <= cfg_wdata_i[LimitW-1:0];
        CFG_FAST_ALPHA:   cfg_q.fast_alpha   <= cfg_wdata_i[AlphaW-1:0];
        CFG_TIMEOUT_MS:   cfg_q.timeout_ms   <= cfg_wdata_i[TimeoutW-1:0];
        default: begin
        end
      endcase
    end
  end

  lcff_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (win_push),
    .raw_i  (win_raw),
    .sum_o  (win_sum),
    .fill_o (win_fill)
  );

  lcff_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  lcff_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_i       (cfg_q),
    .win_push_o  (win_push),
    .win_raw_o   (win_raw),
    .win_sum_i   (win_sum),
    .win_fill_i  (win_fill),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_prod_i  (mul_prod)
  );

  // One item at a time: the sequencer leaves its idle step after an accept.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in work");

  // A rejected glitch never writes the forces.
  a_glitch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.glitch_rejected |-> !out_data_o.forces_updated)
    else $error("glitch item reported a force update");

  // With zero gain an updating item leaves both forces at zero.
  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.forces_updated && cfg_q.gain == '0
    |-> out_data_o.force_average == '0 && out_data_o.force_fast == '0)
    else $error("nonzero force with gain disabled");

endmodule
